// File: rtl/audio_input_gain_and_peak_tracker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio input gain and peak tracker
// Shared property templates, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef AUDIO_INPUT_GAIN_AND_PEAK_TRACKER_DEFINES_SVH
`define AUDIO_INPUT_GAIN_AND_PEAK_TRACKER_DEFINES_SVH

// expr must hold at every clock edge out of reset
`define AIGPT_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// cause in this cycle implies effect in the next one
`define AIGPT_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/aigpt_pkg.sv
// ----------------------------------------------------------------------------
// aigpt_pkg
// Constants, control word layout and microprogram of the gain / peak tracker.
// ----------------------------------------------------------------------------
package aigpt_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int STEP_W = 3;

  // word index of the only register (byte address 0)
  localparam logic [ADDR_W-3:0] REG_DISCARD = '0;

  localparam logic [15:0] DISCARD_RESET = 16'd8000;
  localparam logic [10:0] GAIN_OFFSET   = 11'd128;
  localparam logic [11:0] CODE_OFFSET   = 12'd2048;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] STEP_SMOOTH     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_GAIN   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_SAMPLE = 3'd2;
  localparam logic [STEP_W-1:0] STEP_SATURATE   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FINISH     = 3'd4;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_GAIN,
    MUL_SAMPLE
  } mul_sel_t;

  typedef enum logic {
    COND_NEVER,
    COND_OUT_BUSY
  } jump_cond_t;

  typedef struct packed {
    mul_sel_t            mul_sel;
    logic                smooth_en;
    logic                sat_en;
    logic                finish;
    jump_cond_t          cond;
    logic [STEP_W-1:0]   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t cw;
    cw = '{mul_sel: MUL_NONE, smooth_en: 1'b0, sat_en: 1'b0, finish: 1'b0,
           cond: COND_NEVER, target: STEP_SMOOTH};
    case (step)
      STEP_SMOOTH:     cw.smooth_en = 1'b1;
      STEP_MUL_GAIN:   cw.mul_sel = MUL_GAIN;
      STEP_MUL_SAMPLE: cw.mul_sel = MUL_SAMPLE;
      STEP_SATURATE:   cw.sat_en = 1'b1;
      STEP_FINISH: begin
        // spin here while the output register still holds an untaken word
        cw.finish = 1'b1;
        cw.cond   = COND_OUT_BUSY;
        cw.target = STEP_FINISH;
      end
      default: cw.finish = 1'b1;
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/audio_input_gain_and_peak_tracker.sv
// ----------------------------------------------------------------------------
// audio_input_gain_and_peak_tracker
// Slider-controlled gain, saturation, peak follower and offset code output,
// run by a five-step microprogram around one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  in       | in_valid / in_stall      | slider_raw, audio_raw
//  out      | out_valid / out_stall    | sample_code, forwarded, peak_level
//  config   | psel/penable/pwrite/...  | discard_after_start @ 0x0
//
//  A word runs through the steps smooth, gain product, sample product, saturate,
//  finish; the single 18x17 multiplier is used in two of them.
//  The next word is taken in the finish cycle of the current one.
//  While a result waits on out_stall the finish step repeats and in_stall holds.
//  Synchronous reset clears control, state and the register to 8000.
// ----------------------------------------------------------------------------
`include "audio_input_gain_and_peak_tracker_defines.svh"

module audio_input_gain_and_peak_tracker
  import aigpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       slider_raw,
  input  logic [15:0]       audio_raw,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       sample_code,
  output logic              forwarded,
  output logic [15:0]       peak_level,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic              busy;
  logic [STEP_W-1:0] step;
  ucode_t            cw;
  logic              jump;
  logic              done;
  logic              in_acc;
  logic              out_acc;
  logic              cfg_wr;

  logic [15:0]        discard_after_start;
  logic [15:0]        discard_left;
  logic [4:0]         sample_phase;
  logic [15:0]        smoothed_slider;
  logic [15:0]        peak_value;

  logic [15:0]        slider;
  logic signed [16:0] sample;
  logic               wrap;
  logic signed [34:0] prod;
  logic signed [15:0] sat;

  logic [21:0]        smooth_sum;
  logic [10:0]        gain;
  logic signed [17:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [34:0] prod_sh;
  logic [15:0]        rect;
  logic [31:0]        decay_sum;
  logic [15:0]        peak_next;
  logic signed [15:0] sat_sh;

  // control
  assign cw      = ucode_rom(step);
  assign jump    = (cw.cond == COND_OUT_BUSY) && out_valid && out_stall;
  assign done    = busy && cw.finish && !jump;
  assign in_stall = busy && !done;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_DISCARD);
  assign prdata = (paddr[ADDR_W-1:2] == REG_DISCARD) ?
                  {{(DATA_W-16){1'b0}}, discard_after_start} : '0;

  // datapath
  always_comb begin
    // slider + 63 * smoothed
    smooth_sum = {smoothed_slider, 6'b0} - {6'b0, smoothed_slider} + {6'b0, slider};
    gain = {1'b0, prod[30:21]} + GAIN_OFFSET;
    case (cw.mul_sel)
      MUL_GAIN: begin
        mul_a = $signed({3'b0, smoothed_slider[15:1]});
        mul_b = $signed({1'b0, smoothed_slider});
      end
      MUL_SAMPLE: begin
        mul_a = {sample[16], sample};
        mul_b = $signed({6'b0, gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_sh = prod >>> 8;
    rect = sat[15] ? (16'd0 - $unsigned(sat)) : $unsigned(sat);
    decay_sum = {1'b0, peak_value, 15'b0} - {16'b0, peak_value} + {16'b0, rect};
    peak_next = (rect > peak_value) ? rect : decay_sum[30:15];
    sat_sh = sat >>> 6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy                <= 1'b0;
      step                <= STEP_SMOOTH;
      out_valid           <= 1'b0;
      sample_phase        <= '0;
      smoothed_slider     <= '0;
      peak_value          <= '0;
      discard_after_start <= DISCARD_RESET;
      discard_left        <= DISCARD_RESET;
    end else begin
      if (cfg_wr) begin
        discard_after_start <= pwdata[15:0];
        discard_left        <= pwdata[15:0];
      end

      if (in_acc) begin
        sample_phase <= sample_phase + 5'd1;
        busy         <= 1'b1;
        step         <= STEP_SMOOTH;
      end else if (done) begin
        busy <= 1'b0;
        step <= STEP_SMOOTH;
      end else if (busy) begin
        step <= jump ? cw.target : step + 3'd1;
      end

      if (busy && cw.smooth_en && wrap) begin
        smoothed_slider <= smooth_sum[21:6];
      end

      if (out_acc) begin
        out_valid <= 1'b0;
      end
      if (done) begin
        out_valid  <= 1'b1;
        peak_value <= peak_next;
        if (discard_left != 16'd0) begin
          discard_left <= discard_left - 16'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slider <= ~slider_raw;
      sample <= 17'sd32768 - $signed({1'b0, audio_raw});
      wrap   <= &sample_phase;
    end
    if (busy && (cw.mul_sel != MUL_NONE)) begin
      prod <= mul_a * mul_b;
    end
    if (busy && cw.sat_en) begin
      if (prod_sh > 35'sd32767) begin
        sat <= 16'sh7fff;
      end else if (prod_sh < -35'sd32768) begin
        sat <= 16'sh8000;
      end else begin
        sat <= prod_sh[15:0];
      end
    end
    if (done) begin
      sample_code <= CODE_OFFSET + sat_sh[11:0];
      forwarded   <= (discard_left == 16'd0);
      peak_level  <= peak_next;
    end
  end

  `AIGPT_ASSERT_NEXT(a_accept_starts, in_acc, busy && (step == STEP_SMOOTH))
  `AIGPT_ASSERT_NEXT(a_done_shows_word, done, out_valid)
  `AIGPT_ASSERT_ALWAYS(a_step_in_program, !busy || (step <= STEP_FINISH))
  `AIGPT_ASSERT_ALWAYS(a_peak_bounded, peak_value <= 16'd32768)

endmodule
